// ===== hw/rtl/lpd_pkg.sv =====
// lpd_pkg: types, codes and constants shared by the length-prefixed deframer
// used by lpd_regs, lpd_parser, lpd_skid and length_prefixed_deframer
`default_nettype none

package lpd_pkg;

  // frame header
  localparam int LENGTH_BYTES = 4;
  localparam int LEN_W        = 32;
  localparam int CNT_W        = 2;
  localparam logic [CNT_W-1:0] HDR_LAST = CNT_W'(LENGTH_BYTES - 1);

  // configuration port
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 64;
  localparam int REG_IDX_W = 3;
  localparam logic [LEN_W-1:0] MAX_BODY_RESET = 32'd65536;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MAX_BODY = 3'd0,
    REG_KNOWN_0  = 3'd1,
    REG_KNOWN_1  = 3'd2,
    REG_KNOWN_2  = 3'd3,
    REG_KNOWN_3  = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_TYPE    = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_DEAD    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_SIZE = 2'd1,
    ERR_TYPE = 2'd2
  } err_t;

  typedef struct packed {
    logic [LEN_W-1:0] max_body_size;
    logic [255:0]     known_types;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] msg_type;
    logic [7:0] data;
    logic       last;
    err_t       error_code;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/length_prefixed_deframer.sv =====
// length_prefixed_deframer: top level, wires registers, parser and output buffer
// depends on lpd_pkg, lpd_regs, lpd_parser, lpd_skid
`default_nettype none

// Takes one stream byte per cycle on in_byte while in_stall is low. Frames are a
// 4-byte big-endian body length, a type byte and then length-1 payload bytes.
// Every payload byte comes out with its frame type and a last flag; an empty
// payload gives one marker result on the type byte. A length of zero or over
// max_body_size, or a type whose bit is clear in known_types, gives one error
// result and the block then drops every byte until reset. Per-byte state update
// (32-bit length compare, payload counter, type mask lookup) is combinational;
// its result is registered, and waits in the skid entry while out_stall holds
// the output register. A one-entry skid stage behind it lets input keep flowing
// for one request while out_stall is high; in_stall rises only when both are
// full. Registers sit at byte addresses 8*i on the 64-bit apb-style port.

module length_prefixed_deframer (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lpd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [lpd_pkg::DATA_W-1:0] pwdata,
  output logic      [lpd_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [7:0]                 in_byte,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [1:0]                 out_kind,
  output logic      [7:0]                 msg_type,
  output logic      [7:0]                 data,
  output logic                            last,
  output logic      [1:0]                 error_code
);
  import lpd_pkg::*;

  cfg_t    cfg;
  logic    take;
  logic    res_valid;
  result_t res;
  logic    full;
  result_t out_res;

  assign in_stall = full;
  assign take     = in_valid && !in_stall;

  lpd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lpd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .in_byte   (in_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  lpd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (take && res_valid),
    .push_res  (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind   = out_res.kind;
  assign msg_type   = out_res.msg_type;
  assign data       = out_res.data;
  assign last       = out_res.last;
  assign error_code = out_res.error_code;

endmodule

`default_nettype wire

// ===== hw/rtl/lpd_regs.sv =====
// lpd_regs: apb-style configuration registers (size limit and known-type mask)
// depends on lpd_pkg
`default_nettype none

module lpd_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lpd_pkg::ADDR_W-1:0] paddr,
  input  wire logic [lpd_pkg::DATA_W-1:0] pwdata,
  output logic      [lpd_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output lpd_pkg::cfg_t                   cfg
);
  import lpd_pkg::*;

  logic [LEN_W-1:0]  max_body_size;
  logic [DATA_W-1:0] known_0;
  logic [DATA_W-1:0] known_1;
  logic [DATA_W-1:0] known_2;
  logic [DATA_W-1:0] known_3;
  logic              wr_en;
  reg_idx_t          idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  // registers sit on 8-byte boundaries, low address bits are ignored
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:ADDR_W-REG_IDX_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_size <= MAX_BODY_RESET;
      known_0       <= '0;
      known_1       <= '0;
      known_2       <= '0;
      known_3       <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_MAX_BODY: max_body_size <= pwdata[LEN_W-1:0];
        REG_KNOWN_0:  known_0 <= pwdata;
        REG_KNOWN_1:  known_1 <= pwdata;
        REG_KNOWN_2:  known_2 <= pwdata;
        REG_KNOWN_3:  known_3 <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MAX_BODY: prdata = {{(DATA_W-LEN_W){1'b0}}, max_body_size};
      REG_KNOWN_0:  prdata = known_0;
      REG_KNOWN_1:  prdata = known_1;
      REG_KNOWN_2:  prdata = known_2;
      REG_KNOWN_3:  prdata = known_3;
      default:      prdata = '0;
    endcase
  end

  assign cfg.max_body_size = max_body_size;
  assign cfg.known_types   = {known_3, known_2, known_1, known_0};

endmodule

`default_nettype wire

// ===== hw/rtl/lpd_parser.sv =====
// lpd_parser: frame state machine, one byte per cycle on take, at most one result
// depends on lpd_pkg
`default_nettype none

module lpd_parser (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            take,
  input  wire logic [7:0]      in_byte,
  input  wire lpd_pkg::cfg_t   cfg,
  output logic                 res_valid,
  output lpd_pkg::result_t     res
);
  import lpd_pkg::*;

  phase_t           phase;
  phase_t           phase_next;
  logic [CNT_W-1:0] header_count;
  logic [CNT_W-1:0] header_count_next;
  logic [LEN_W-1:0] length_accum;
  logic [LEN_W-1:0] length_accum_next;
  logic [LEN_W-1:0] bytes_left;
  logic [LEN_W-1:0] bytes_left_next;
  logic [7:0]       frame_type;
  logic [7:0]       frame_type_next;

  logic [LEN_W-1:0] len_full;
  logic             hdr_done;
  logic             size_bad;
  logic             type_known;
  logic             pay_last;

  assign len_full   = {length_accum[LEN_W-9:0], in_byte};
  assign hdr_done   = (header_count == HDR_LAST);
  assign size_bad   = (len_full == '0) || (len_full > cfg.max_body_size);
  assign type_known = cfg.known_types[in_byte];
  assign pay_last   = (bytes_left <= LEN_W'(1));

  // next state
  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    length_accum_next = length_accum;
    bytes_left_next   = bytes_left;
    frame_type_next   = frame_type;
    if (take) begin
      case (phase)
        PH_HEADER: begin
          if (hdr_done) begin
            header_count_next = '0;
            length_accum_next = '0;
            if (size_bad) begin
              phase_next = PH_DEAD;
            end else begin
              bytes_left_next = len_full - LEN_W'(1);
              phase_next      = PH_TYPE;
            end
          end else begin
            header_count_next = header_count + CNT_W'(1);
            length_accum_next = len_full;
          end
        end
        PH_TYPE: begin
          frame_type_next = in_byte;
          if (!type_known) begin
            phase_next = PH_DEAD;
          end else if (bytes_left == '0) begin
            phase_next = PH_HEADER;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (pay_last) begin
            bytes_left_next = '0;
            phase_next      = PH_HEADER;
          end else begin
            bytes_left_next = bytes_left - LEN_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // result for the byte on the input this cycle
  always_comb begin
    res_valid      = 1'b0;
    res.kind       = KIND_PAYLOAD;
    res.msg_type   = '0;
    res.data       = '0;
    res.last       = 1'b1;
    res.error_code = ERR_NONE;
    case (phase)
      PH_HEADER: begin
        if (hdr_done && size_bad) begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_SIZE;
        end
      end
      PH_TYPE: begin
        res.msg_type = in_byte;
        if (!type_known) begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_TYPE;
        end else if (bytes_left == '0) begin
          res_valid = 1'b1;
          res.kind  = KIND_EMPTY;
        end
      end
      PH_PAYLOAD: begin
        res_valid    = 1'b1;
        res.msg_type = frame_type;
        res.data     = in_byte;
        res.last     = pay_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_count <= '0;
      length_accum <= '0;
      bytes_left   <= '0;
      frame_type   <= '0;
    end else begin
      phase        <= phase_next;
      header_count <= header_count_next;
      length_accum <= length_accum_next;
      bytes_left   <= bytes_left_next;
      frame_type   <= frame_type_next;
    end
  end

  a_dead_silent: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DEAD) |-> !res_valid)
    else $error("result produced while dead");

  a_error_kills: assert property (@(posedge clk) disable iff (rst)
    (take && res_valid && res.kind == KIND_ERROR) |=> (phase == PH_DEAD))
    else $error("error result without entering dead phase");

  a_count_in_header: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_HEADER) |-> (header_count == '0 && length_accum == '0))
    else $error("header state left over outside header phase");

endmodule

`default_nettype wire

// ===== hw/rtl/lpd_skid.sv =====
// lpd_skid: registered result output with a one-entry skid stage
// depends on lpd_pkg
`default_nettype none

module lpd_skid (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire lpd_pkg::result_t push_res,
  output logic                  full,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output lpd_pkg::result_t      out_res
);
  import lpd_pkg::*;

  logic    skid_valid;
  result_t skid_res;
  logic    drain;

  assign drain = !out_valid || !out_stall;
  // input side only waits on the skid entry, no path from out_stall
  assign full  = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      if (skid_valid) begin
        out_res <= skid_res;
        if (push) begin
          skid_res <= push_res;
        end
      end else if (push) begin
        out_res <= push_res;
      end
    end else if (push) begin
      skid_res <= push_res;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_valid && out_stall) |-> !push)
    else $error("result pushed into full buffer");

endmodule

`default_nettype wire
